// ===== rtl/core/pid_position_controller_defines.svh =====
// Assertion macros for the PID position controller RTL.
// Used by pid_position_controller.sv; no other dependencies.
`ifndef PID_POSITION_CONTROLLER_DEFINES_SVH
`define PID_POSITION_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clock, off during reset.
`define PIDPC_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, sampled on clock, off during reset.
`define PIDPC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define PIDPC_ASSERT_IMPL(label, ante, cons, msg)
`define PIDPC_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== rtl/core/pidpc_pkg.sv =====
// Package for the PID position controller: field widths, derived datapath
// widths, saturation constants and register index codes. No dependencies.
package pidpc_pkg;

   localparam int SAMPLE_W = 16;   // measured sample width
   localparam int FRAC_W   = 16;   // fraction bits of the gains
   localparam int GAIN_W   = 24;
   localparam int SETPT_W  = 16;
   localparam int OUT_W    = 16;
   localparam int SUM_W    = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam int ERR_W = ((SAMPLE_W > SETPT_W) ? SAMPLE_W : SETPT_W) + 1;
   localparam int DE_W  = ERR_W + 1;
   localparam int ACC_W = ((SUM_W > ERR_W) ? SUM_W : ERR_W) + 1;
   localparam int PP_W  = GAIN_W + 1 + ERR_W;
   localparam int PI_W  = GAIN_W + 1 + SUM_W;
   localparam int PD_W  = GAIN_W + 1 + DE_W;
   localparam int PMAX_W = (PP_W > PI_W) ? ((PP_W > PD_W) ? PP_W : PD_W)
                                          : ((PI_W > PD_W) ? PI_W : PD_W);
   localparam int TOT_W = PMAX_W + 2;
   localparam int Q_W   = TOT_W - FRAC_W;

   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
   localparam logic signed [OUT_W-1:0] OUT_MAX_RST = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic signed [OUT_W-1:0] OUT_MIN_RST = {1'b1, {(OUT_W-1){1'b0}}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SETPOINT       = 3'd0,
      CSR_GAIN_P         = 3'd1,
      CSR_GAIN_I         = 3'd2,
      CSR_GAIN_D         = 3'd3,
      CSR_SUM_LIMIT_HIGH = 3'd4,
      CSR_SUM_LIMIT_LOW  = 3'd5,
      CSR_OUT_MAX        = 3'd6,
      CSR_OUT_MIN        = 3'd7
   } csr_index_type;

endpackage

// ===== rtl/core/pid_position_controller.sv =====
// PID position controller top level: register file, error/sum update,
// three-multiplier datapath and output clamp. Uses pidpc_pkg and
// pid_position_controller_defines.svh.
//
//  channel  direction  handshake           payload
//  req      in         req_valid/req_stall req_measured
//  rsp      out        rsp_valid/rsp_stall rsp_drive, rsp_clamped
//  csr      in         csr_valid/csr_ready csr_index, csr_wdata
//
// One sample enters per cycle while no held result stalls the input; the drive
// reaches the result port through the sum update, multiply, add, and shift and
// clamp steps, one register each. The error sum and error history update at
// the input transfer, so the combinational sum add and saturate loop sets the
// rate.
// Reset (synchronous) clears history, sum and pipeline, and loads register defaults.
// A held result stalls the stages behind it; empty stages still fill.
`include "pid_position_controller_defines.svh"

module pid_position_controller (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [pidpc_pkg::SAMPLE_W-1:0]  req_measured,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [pidpc_pkg::OUT_W-1:0]     rsp_drive,
   output logic                                   rsp_clamped,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [pidpc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [pidpc_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   // configuration registers
   logic signed [pidpc_pkg::SETPT_W-1:0] setpoint_ff;
   logic [pidpc_pkg::GAIN_W-1:0]         gain_p_ff;
   logic [pidpc_pkg::GAIN_W-1:0]         gain_i_ff;
   logic [pidpc_pkg::GAIN_W-1:0]         gain_d_ff;
   logic signed [pidpc_pkg::SUM_W-1:0]   sum_limit_high_ff;
   logic signed [pidpc_pkg::SUM_W-1:0]   sum_limit_low_ff;
   logic signed [pidpc_pkg::OUT_W-1:0]   out_max_ff;
   logic signed [pidpc_pkg::OUT_W-1:0]   out_min_ff;

   // controller state
   logic signed [pidpc_pkg::SUM_W-1:0]   error_sum_ff;
   logic signed [pidpc_pkg::SUM_W-1:0]   error_sum_in;
   logic signed [pidpc_pkg::ERR_W-1:0]   prev_error_ff;
   logic signed [pidpc_pkg::ERR_W-1:0]   prev_prev_error_ff;

   // stage 1: error, clamped sum, derivative difference
   logic                                 s1_valid_ff;
   logic signed [pidpc_pkg::ERR_W-1:0]   s1_err_ff;
   logic signed [pidpc_pkg::SUM_W-1:0]   s1_sum_ff;
   logic signed [pidpc_pkg::DE_W-1:0]    s1_de_ff;

   // stage 2: products
   logic                                 s2_valid_ff;
   logic signed [pidpc_pkg::PP_W-1:0]    s2_prod_p_ff;
   logic signed [pidpc_pkg::PI_W-1:0]    s2_prod_i_ff;
   logic signed [pidpc_pkg::PD_W-1:0]    s2_prod_d_ff;

   // stage 3: total
   logic                                 s3_valid_ff;
   logic signed [pidpc_pkg::TOT_W-1:0]   s3_total_ff;

   // result register
   logic                                 rsp_valid_ff;
   logic signed [pidpc_pkg::OUT_W-1:0]   rsp_drive_ff;
   logic                                 rsp_clamped_ff;

   logic                                 req_accept;
   logic                                 out_free;
   logic                                 adv3;
   logic                                 adv2;
   logic                                 adv1;

   logic signed [pidpc_pkg::ERR_W-1:0]   err;
   logic signed [pidpc_pkg::ACC_W-1:0]   acc;
   logic [pidpc_pkg::ACC_W-pidpc_pkg::SUM_W:0] acc_top;
   logic                                 acc_ovf;
   logic signed [pidpc_pkg::SUM_W-1:0]   sum_sat;
   logic signed [pidpc_pkg::DE_W-1:0]    de;

   logic signed [pidpc_pkg::GAIN_W:0]    gain_p_s;
   logic signed [pidpc_pkg::GAIN_W:0]    gain_i_s;
   logic signed [pidpc_pkg::GAIN_W:0]    gain_d_s;
   logic signed [pidpc_pkg::PP_W-1:0]    prod_p;
   logic signed [pidpc_pkg::PI_W-1:0]    prod_i;
   logic signed [pidpc_pkg::PD_W-1:0]    prod_d;
   logic signed [pidpc_pkg::TOT_W-1:0]   total;

   logic signed [pidpc_pkg::Q_W-1:0]     quot;
   logic signed [pidpc_pkg::OUT_W-1:0]   drive_in;
   logic                                 clamped_in;

   // ---------------------------------------------------------------- flow
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign adv3       = !s3_valid_ff || out_free;
   assign adv2       = !s2_valid_ff || adv3;
   assign adv1       = !s1_valid_ff || adv2;
   assign req_stall  = !adv1;
   assign req_accept = req_valid && adv1;
   assign csr_ready  = 1'b1;

   // ---------------------------------------------------------------- csr
   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff       <= '0;
         gain_p_ff         <= '0;
         gain_i_ff         <= '0;
         gain_d_ff         <= '0;
         sum_limit_high_ff <= pidpc_pkg::SUM_MAX;
         sum_limit_low_ff  <= pidpc_pkg::SUM_MIN;
         out_max_ff        <= pidpc_pkg::OUT_MAX_RST;
         out_min_ff        <= pidpc_pkg::OUT_MIN_RST;
      end else if (csr_valid && csr_ready) begin
         case (pidpc_pkg::csr_index_type'(csr_index))
            pidpc_pkg::CSR_SETPOINT: begin
               setpoint_ff <= csr_wdata[pidpc_pkg::SETPT_W-1:0];
            end
            pidpc_pkg::CSR_GAIN_P: begin
               gain_p_ff <= csr_wdata[pidpc_pkg::GAIN_W-1:0];
            end
            pidpc_pkg::CSR_GAIN_I: begin
               gain_i_ff <= csr_wdata[pidpc_pkg::GAIN_W-1:0];
            end
            pidpc_pkg::CSR_GAIN_D: begin
               gain_d_ff <= csr_wdata[pidpc_pkg::GAIN_W-1:0];
            end
            pidpc_pkg::CSR_SUM_LIMIT_HIGH: begin
               sum_limit_high_ff <= csr_wdata[pidpc_pkg::SUM_W-1:0];
            end
            pidpc_pkg::CSR_SUM_LIMIT_LOW: begin
               sum_limit_low_ff <= csr_wdata[pidpc_pkg::SUM_W-1:0];
            end
            pidpc_pkg::CSR_OUT_MAX: begin
               out_max_ff <= csr_wdata[pidpc_pkg::OUT_W-1:0];
            end
            pidpc_pkg::CSR_OUT_MIN: begin
               out_min_ff <= csr_wdata[pidpc_pkg::OUT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- stage 0
   always_comb begin
      err     = pidpc_pkg::ERR_W'(setpoint_ff) - pidpc_pkg::ERR_W'(req_measured);
      acc     = pidpc_pkg::ACC_W'(error_sum_ff) + pidpc_pkg::ACC_W'(err);
      acc_top = acc[pidpc_pkg::ACC_W-1:pidpc_pkg::SUM_W-1];
      acc_ovf = (acc_top != '0) && (acc_top != '1);
      if (acc_ovf) begin
         sum_sat = acc[pidpc_pkg::ACC_W-1] ? pidpc_pkg::SUM_MIN : pidpc_pkg::SUM_MAX;
      end else begin
         sum_sat = acc[pidpc_pkg::SUM_W-1:0];
      end
      // high limit wins when the limits are inverted
      error_sum_in = sum_sat;
      if (gain_i_ff != '0) begin
         if (sum_sat > sum_limit_high_ff) begin
            error_sum_in = sum_limit_high_ff;
         end else if (sum_sat < sum_limit_low_ff) begin
            error_sum_in = sum_limit_low_ff;
         end
      end
      de = pidpc_pkg::DE_W'(prev_error_ff) - pidpc_pkg::DE_W'(prev_prev_error_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         error_sum_ff       <= '0;
         prev_error_ff      <= '0;
         prev_prev_error_ff <= '0;
         s1_valid_ff        <= 1'b0;
      end else begin
         if (adv1) begin
            s1_valid_ff <= req_valid;
         end
         if (req_accept) begin
            error_sum_ff       <= error_sum_in;
            prev_prev_error_ff <= prev_error_ff;
            prev_error_ff      <= err;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_err_ff <= err;
         s1_sum_ff <= error_sum_in;
         s1_de_ff  <= de;
      end
   end

   // ---------------------------------------------------------------- stage 1
   assign gain_p_s = $signed({1'b0, gain_p_ff});
   assign gain_i_s = $signed({1'b0, gain_i_ff});
   assign gain_d_s = $signed({1'b0, gain_d_ff});
   assign prod_p   = gain_p_s * s1_err_ff;
   assign prod_i   = gain_i_s * s1_sum_ff;
   assign prod_d   = gain_d_s * s1_de_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv2) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv2 && s1_valid_ff) begin
         s2_prod_p_ff <= prod_p;
         s2_prod_i_ff <= prod_i;
         s2_prod_d_ff <= prod_d;
      end
   end

   // ---------------------------------------------------------------- stage 2
   assign total = pidpc_pkg::TOT_W'(s2_prod_p_ff) + pidpc_pkg::TOT_W'(s2_prod_i_ff)
                + pidpc_pkg::TOT_W'(s2_prod_d_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv3) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv3 && s2_valid_ff) begin
         s3_total_ff <= total;
      end
   end

   // ---------------------------------------------------------------- stage 3
   always_comb begin
      // dropping the fraction bits of a two's complement value floors it
      quot       = s3_total_ff[pidpc_pkg::TOT_W-1:pidpc_pkg::FRAC_W];
      drive_in   = quot[pidpc_pkg::OUT_W-1:0];
      clamped_in = 1'b0;
      // low limit wins when the limits are inverted
      if (quot < pidpc_pkg::Q_W'(out_min_ff)) begin
         drive_in   = out_min_ff;
         clamped_in = 1'b1;
      end else if (quot > pidpc_pkg::Q_W'(out_max_ff)) begin
         drive_in   = out_max_ff;
         clamped_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && s3_valid_ff) begin
         rsp_drive_ff   <= drive_in;
         rsp_clamped_ff <= clamped_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_drive   = rsp_drive_ff;
   assign rsp_clamped = rsp_clamped_ff;

   // ---------------------------------------------------------------- checks
   `PIDPC_ASSERT_IMPL(a_clamp_at_limit, rsp_valid_ff && rsp_clamped_ff,
      (rsp_drive_ff == out_min_ff) || (rsp_drive_ff == out_max_ff),
      "clamped drive is not at an output limit")
   `PIDPC_ASSERT_NEXT(a_sum_in_limits,
      req_accept && (gain_i_ff != '0) && (sum_limit_low_ff <= sum_limit_high_ff),
      (s1_sum_ff <= $past(sum_limit_high_ff)) && (s1_sum_ff >= $past(sum_limit_low_ff)),
      "error sum escaped its limits")
   `PIDPC_ASSERT_IMPL(a_stall_only_full, req_stall,
      s1_valid_ff && s2_valid_ff && s3_valid_ff && rsp_valid_ff,
      "input stalled while a stage is empty")

endmodule
